[rtl/core/egcd_pkg.sv]
package egcd_pkg;

  localparam int unsigned OperandWidth = 63;
  localparam int unsigned CoefWidth = 64;

endpackage

[rtl/core/egcd_divider.sv]
module egcd_divider #(
  parameter int unsigned OPERAND_WIDTH = egcd_pkg::OperandWidth
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] dividend,
  input  logic [OPERAND_WIDTH-1:0] divisor,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] quotient,
  output logic [OPERAND_WIDTH-1:0] remainder
);

  localparam int unsigned CntWidth = $clog2(OPERAND_WIDTH + 1);

  logic                     busy;
  logic [CntWidth-1:0]      count;
  logic [OPERAND_WIDTH-1:0] dvs;
  logic [OPERAND_WIDTH:0]   trial;
  logic [OPERAND_WIDTH:0]   diff;

  // restoring division, one quotient bit per cycle
  assign trial = {remainder, quotient[OPERAND_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CntWidth'(OPERAND_WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (!diff[OPERAND_WIDTH]) begin
        remainder <= diff[OPERAND_WIDTH-1:0];
        quotient  <= {quotient[OPERAND_WIDTH-2:0], 1'b1};
      end else begin
        remainder <= trial[OPERAND_WIDTH-1:0];
        quotient  <= {quotient[OPERAND_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/core/extended_gcd_with_bound.sv]
// Extended Euclid with optional early stop. An item is taken when idle; each
// Euclid step runs one serial division (S_DIV), then two coefficient updates
// (S_MULU, S_MULV) on one shared shift-add unit, plus one control state
// (S_CHECK), for up to about 92 steps with 63-bit operands.
// The result sits in an output register; the next item is taken once the
// result transfer completes.
module extended_gcd_with_bound #(
  parameter int unsigned OPERAND_WIDTH = egcd_pkg::OperandWidth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operand_a, operand_b, stop_bound, zero fill
  input  logic [191:0] s_tdata,
  // use_bound
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // remainder_g, coef_a, coef_b, zero fill
  output logic [191:0] m_tdata
);

  localparam int unsigned CW = egcd_pkg::CoefWidth;
  localparam int unsigned CntWidth = $clog2(OPERAND_WIDTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_MULU  = 6'b001000,
    S_MULV  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [OPERAND_WIDTH-1:0] prev_r, cur_r, limit;
  logic bounded;
  logic [CW-1:0] pu, pv, cu, cv;
  logic [OPERAND_WIDTH-1:0] q, msh;
  logic [CW-1:0] acc, mcand;
  logic [CntWidth-1:0] mcnt;
  logic [62:0] out_g;
  logic [CW-1:0] out_u, out_v;

  logic div_start;
  logic div_done;
  logic [OPERAND_WIDTH-1:0] quo, rem;

  assign div_start = (state == S_CHECK) && (cur_r != '0) && !(bounded && cur_r <= limit);

  egcd_divider #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prev_r),
    .divisor  (cur_r),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {1'b0, out_v, out_u, out_g};

  // control FSM, with the shared shift-add unit: acc accumulates q * mcand
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            prev_r  <= s_tdata[OPERAND_WIDTH-1:0];
            cur_r   <= s_tdata[63+OPERAND_WIDTH-1:63];
            limit   <= s_tdata[126+OPERAND_WIDTH-1:126];
            bounded <= s_tuser;
            pu <= CW'(1); pv <= '0; cu <= '0; cv <= CW'(1);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            if (bounded) begin
              out_g <= 63'(cur_r); out_u <= cu; out_v <= cv;
            end else begin
              out_g <= 63'(prev_r); out_u <= pu; out_v <= pv;
            end
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            q <= quo; msh <= quo; acc <= '0; mcand <= cu;
            mcnt <= CntWidth'(OPERAND_WIDTH);
            state <= S_MULU;
          end
        end
        S_MULU: begin
          if (mcnt == CntWidth'(1)) begin
            pu <= cu;
            cu <= pu - (msh[0] ? acc + mcand : acc);
            msh <= q; acc <= '0; mcand <= cv;
            mcnt <= CntWidth'(OPERAND_WIDTH);
            state <= S_MULV;
          end else begin
            if (msh[0]) acc <= acc + mcand;
            msh   <= msh >> 1;
            mcand <= mcand << 1;
            mcnt  <= mcnt - 1'b1;
          end
        end
        S_MULV: begin
          if (mcnt == CntWidth'(1)) begin
            pv <= cv;
            cv <= pv - (msh[0] ? acc + mcand : acc);
            prev_r <= cur_r;
            cur_r  <= rem;
            state  <= S_CHECK;
          end else begin
            if (msh[0]) acc <= acc + mcand;
            msh   <= msh >> 1;
            mcand <= mcand << 1;
            mcnt  <= mcnt - 1'b1;
          end
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
